>>> design/f2i_pkg.sv
// Package for the float-to-integer converter: payload structs and codes.
// No dependencies.
package f2i_pkg;

  localparam logic [1:0] FMT_HALF   = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;

  localparam logic [1:0] WID_16 = 2'd0;
  localparam logic [1:0] WID_32 = 2'd1;

  localparam logic [2:0] RM_RNE = 3'd0;
  localparam logic [2:0] RM_RTZ = 3'd1;
  localparam logic [2:0] RM_RDN = 3'd2;
  localparam logic [2:0] RM_RUP = 3'd3;
  localparam logic [2:0] RM_RMM = 3'd4;
  localparam logic [2:0] RM_ODD = 3'd5;

  typedef struct packed {
    logic [63:0] operand_bits;
    logic [1:0]  source_format;
    logic        target_signed;
    logic [1:0]  target_width;
    logic [2:0]  rounding_mode;
    logic        report_inexact;
  } f2i_in_t;

  typedef struct packed {
    logic [63:0] integer_result;
    logic        invalid_flag;
    logic        inexact_flag;
  } f2i_out_t;

  // Unpacked operand, handed from the decode stage to the rounding stage.
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic [52:0] sig;
    logic [12:0] exp_s;    // signed unbiased exponent of the sig LSB
    logic        tsigned;
    logic [1:0]  wcode;
    logic [2:0]  mode;
    logic        report;
  } f2i_dec_t;

endpackage

>>> design/float_to_integer_converter.sv
// Float-to-integer converter, top level. out_valid follows start through
// the input register, then the result register; it accepts one
// conversion per cycle, set by the single decode/round pass. busy is
// always low and the receiver cannot stall. Synchronous active-low reset
// clears the valid bits. Depends on f2i_pkg, f2i_decode, f2i_round.
module float_to_integer_converter import f2i_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  f2i_in_t  in_item,
  output logic     out_valid,
  output f2i_out_t out_item
);

  f2i_in_t  in_r;
  logic     in_vld_r;
  f2i_dec_t dec;
  f2i_out_t res;
  logic     out_vld_r;
  f2i_out_t out_r;

  assign busy = 1'b0;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) in_r <= in_item;
    if (in_vld_r) out_r <= res;
  end

  f2i_decode u_dec (.in_item(in_r), .dec(dec));
  f2i_round  u_rnd (.dec(dec), .res(res));

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // each accepted transaction yields a result through the input and result registers
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid) else $error("missing result");
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.inexact_flag |-> !out_item.invalid_flag)
    else $error("invalid and inexact together");
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r)) else $error("result without transaction");

endmodule

>>> design/f2i_decode.sv
// Format decode for the float-to-integer converter: splits the operand
// into sign, significand and exponent. Depends on f2i_pkg.
module f2i_decode import f2i_pkg::*; (
  input  f2i_in_t  in_item,
  output f2i_dec_t dec
);

  logic [10:0] expf;
  logic [51:0] frac;
  logic [10:0] emax;
  logic [12:0] bias_m;

  always_comb begin
    case (in_item.source_format)
      FMT_HALF: begin
        dec.sign = in_item.operand_bits[15];
        expf     = {6'd0, in_item.operand_bits[14:10]};
        frac     = {42'd0, in_item.operand_bits[9:0]};
        emax     = 11'd31;
        bias_m   = 13'd25;
      end
      FMT_SINGLE: begin
        dec.sign = in_item.operand_bits[31];
        expf     = {3'd0, in_item.operand_bits[30:23]};
        frac     = {29'd0, in_item.operand_bits[22:0]};
        emax     = 11'd255;
        bias_m   = 13'd150;
      end
      default: begin
        dec.sign = in_item.operand_bits[63];
        expf     = in_item.operand_bits[62:52];
        frac     = in_item.operand_bits[51:0];
        emax     = 11'd2047;
        bias_m   = 13'd1075;
      end
    endcase
    dec.nan = (expf == emax) && (frac != 52'd0);
    dec.inf = (expf == emax) && (frac == 52'd0);
    // hidden bit sits at position mbits, which is where frac ends
    case (in_item.source_format)
      FMT_HALF:   dec.sig = {42'd0, (expf != 11'd0), frac[9:0]};
      FMT_SINGLE: dec.sig = {29'd0, (expf != 11'd0), frac[22:0]};
      default:    dec.sig = {(expf != 11'd0), frac};
    endcase
    dec.exp_s   = ((expf == 11'd0) ? 13'd1 : {2'd0, expf}) - bias_m;
    dec.tsigned = in_item.target_signed;
    dec.wcode   = in_item.target_width;
    dec.mode    = in_item.rounding_mode;
    dec.report  = in_item.report_inexact;
  end

endmodule

>>> design/f2i_round.sv
// Rounding and range check for the float-to-integer converter.
// Depends on f2i_pkg.
module f2i_round import f2i_pkg::*; (
  input  f2i_dec_t dec,
  output f2i_out_t res
);

  logic [116:0] shl;
  logic [5:0]   lsh;
  logic [5:0]   rsh;
  logic [52:0]  rmask;
  logic [52:0]  hmask;
  logic [52:0]  mag_t;
  logic [64:0]  mag;
  logic         g, s, inc, huge, fits, dropped;
  logic [63:0]  wmask, lim, negm;

  always_comb begin
    huge  = dec.inf;
    mag   = 65'd0;
    g     = 1'b0;
    s     = 1'b0;
    lsh   = dec.exp_s[5:0];
    rsh   = 6'd0;
    rmask = '0;
    hmask = '0;
    mag_t = '0;
    shl   = '0;
    inc   = 1'b0;
    if (!dec.exp_s[12]) begin
      // left shift: value is an integer
      shl = {64'd0, dec.sig} << lsh;
      if (dec.sig != 53'd0 &&
          (dec.exp_s > 13'd63 || shl[116:64] != 53'd0)) huge = 1'b1;
      mag = {1'b0, shl[63:0]};
    end else if (dec.exp_s < -13'sd54) begin
      s = (dec.sig != 53'd0);
    end else begin
      rsh   = 6'(-dec.exp_s);
      mag_t = dec.sig >> rsh;
      hmask = 53'd1 << (rsh - 6'd1);
      rmask = (hmask << 1) - 53'd1;
      g     = (dec.sig & hmask) != 53'd0;
      s     = (dec.sig & rmask & ~hmask) != 53'd0;
      mag   = {12'd0, mag_t};
    end
    if (dec.exp_s[12]) begin
      case (dec.mode)
        RM_RTZ: inc = 1'b0;
        RM_RDN: inc = dec.sign && (g || s);
        RM_RUP: inc = !dec.sign && (g || s);
        RM_RMM: inc = g;
        RM_ODD: begin
          inc = 1'b0;
          if (g || s) mag[0] = 1'b1;
        end
        default: inc = g && (s || mag[0]);
      endcase
    end
    mag     = mag + {64'd0, inc};
    dropped = dec.exp_s[12] && (g || s);

    case (dec.wcode)
      WID_16:  begin wmask = 64'h0000_0000_0000_FFFF; lim = 64'h8000; end
      WID_32:  begin wmask = 64'h0000_0000_FFFF_FFFF; lim = 64'h8000_0000; end
      default: begin wmask = '1; lim = 64'h8000_0000_0000_0000; end
    endcase

    if (huge || mag[64]) fits = 1'b0;
    else if (dec.tsigned) fits = dec.sign ? (mag[63:0] <= lim) : (mag[63:0] < lim);
    else fits = dec.sign ? (mag[63:0] == 64'd0) : (mag[63:0] <= wmask);

    negm = 64'd0 - mag[63:0];
    res.integer_result = 64'd0;
    res.invalid_flag   = 1'b0;
    res.inexact_flag   = 1'b0;
    if (dec.nan) begin
      res.invalid_flag = 1'b1;
    end else if (fits) begin
      res.integer_result = (dec.sign ? negm : mag[63:0]) & wmask;
      res.inexact_flag   = dec.report && dropped;
    end else begin
      res.invalid_flag = 1'b1;
      if (dec.tsigned) res.integer_result = dec.sign ? lim : lim - 64'd1;
      else res.integer_result = dec.sign ? 64'd0 : wmask;
    end
  end

endmodule
